@@ hdl/sgm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Scharr gradient block: field widths, filter weights,
// register map, state codes and the structs passed between modules. No dependencies.
package sgm_pkg;

   localparam int PIX_W             = 8;
   localparam int ROW_W             = 12;
   localparam int COL_W             = 10;
   localparam int GRAD_W            = 17;
   localparam int MAG_W             = 17;
   localparam int SQP_W             = 2 * GRAD_W - 2;
   localparam int SQ_W              = SQP_W + 1;
   localparam int TY_W              = 17;
   localparam int IMG_W_W           = 11;
   localparam int IMG_H_W           = 12;
   localparam int MIN_DIM           = 3;
   localparam int W_SIDE            = 47;
   localparam int W_MID             = 162;
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_IDX_WIDTH  = 1'b0;
   localparam logic REG_IDX_HEIGHT = 1'b1;

   localparam int RSP_FIELD_W = ROW_W + COL_W + 2 * GRAD_W + MAG_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CALC
   } sgm_state_type;

   typedef logic [8:0][PIX_W-1:0] sgm_pix_type;

   typedef struct packed {
      logic        valid;
      sgm_pix_type pixels;
   } sgm_win_type;

   typedef struct packed {
      logic             emit;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } sgm_meta_type;

endpackage

@@ hdl/sgm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module sgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/sgm_line.sv @@
`timescale 1ns / 1ps
// Line stores, 3x3 window and raster counters of the Scharr gradient block.
// Uses sgm_pkg and two sgm_ram instances.
module sgm_line #(
   parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [sgm_pkg::PIX_W-1:0]   pixel,
   input  logic [sgm_pkg::IMG_W_W-1:0] image_width,
   input  logic [sgm_pkg::IMG_H_W-1:0] image_height,
   output sgm_pkg::sgm_win_type        win,
   output sgm_pkg::sgm_meta_type       meta
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > sgm_pkg::IMG_W_W) ? CW + 1 : sgm_pkg::IMG_W_W;

   logic [CW-1:0]                 col_cnt_ff, col_cnt_in;
   logic [sgm_pkg::ROW_W-1:0]     row_cnt_ff, row_cnt_in;
   logic [CW-1:0]                 addr_ff;
   logic [sgm_pkg::PIX_W-1:0]     pix_ff;
   logic                          rd_pend_ff;
   logic                          win_valid_ff;
   sgm_pkg::sgm_pix_type          win_ff, win_in;
   sgm_pkg::sgm_meta_type         meta_ff, meta_in;
   logic [sgm_pkg::PIX_W-1:0]     upper_rd, middle_rd;
   logic [WW-1:0]                 w_ext, w_eff, col_m1;
   logic [sgm_pkg::IMG_H_W-1:0]   h_eff;
   logic                          row_end, frame_end;

   sgm_ram #(.WIDTH(sgm_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock (clock),
      .we    (rd_pend_ff),
      .waddr (addr_ff),
      .wdata (middle_rd),
      .raddr (col_cnt_ff),
      .rdata (upper_rd)
   );

   sgm_ram #(.WIDTH(sgm_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock (clock),
      .we    (rd_pend_ff),
      .waddr (addr_ff),
      .wdata (pix_ff),
      .raddr (col_cnt_ff),
      .rdata (middle_rd)
   );

   always_comb begin
      w_ext = WW'(image_width);
      w_eff = w_ext;
      if (w_ext < WW'(sgm_pkg::MIN_DIM)) begin
         w_eff = WW'(sgm_pkg::MIN_DIM);
      end else if (w_ext > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end
      h_eff = image_height;
      if (image_height < sgm_pkg::IMG_H_W'(sgm_pkg::MIN_DIM)) begin
         h_eff = sgm_pkg::IMG_H_W'(sgm_pkg::MIN_DIM);
      end
      row_end   = WW'(col_cnt_ff) >= (w_eff - WW'(1));
      frame_end = row_end && (row_cnt_ff >= (h_eff - sgm_pkg::IMG_H_W'(1)));
      col_m1    = WW'(col_cnt_ff) - WW'(1);

      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      meta_in    = meta_ff;
      if (accept) begin
         if (row_end) begin
            col_cnt_in = '0;
            row_cnt_in = frame_end ? '0 : row_cnt_ff + sgm_pkg::ROW_W'(1);
         end else begin
            col_cnt_in = col_cnt_ff + CW'(1);
         end
         meta_in.emit = (row_cnt_ff >= sgm_pkg::ROW_W'(2)) && (col_cnt_ff >= CW'(2));
         meta_in.last = frame_end;
         meta_in.row  = row_cnt_ff - sgm_pkg::ROW_W'(1);
         meta_in.col  = col_m1[sgm_pkg::COL_W-1:0];
      end

      win_in = win_ff;
      if (rd_pend_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k*3]   = win_ff[k*3+1];
            win_in[k*3+1] = win_ff[k*3+2];
         end
         win_in[2] = upper_rd;
         win_in[5] = middle_rd;
         win_in[8] = pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         win_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         rd_pend_ff   <= accept;
         win_valid_ff <= rd_pend_ff;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
      if (accept) begin
         addr_ff <= col_cnt_ff;
         pix_ff  <= pixel;
      end
   end

   assign win.valid  = win_valid_ff;
   assign win.pixels = win_ff;
   assign meta       = meta_ff;

endmodule

@@ hdl/sgm_grad.sv @@
`timescale 1ns / 1ps
// Four-stage Scharr gradient pipeline: row terms, gradients, squares, sum.
// Uses sgm_pkg.
module sgm_grad (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  sgm_pkg::sgm_pix_type                pixels,
   output logic                                sq_valid,
   output logic [sgm_pkg::SQ_W-1:0]            sq,
   output logic signed [sgm_pkg::GRAD_W-1:0]   grad_x,
   output logic signed [sgm_pkg::GRAD_W-1:0]   grad_y
);

   localparam int SW = sgm_pkg::GRAD_W + 1;
   localparam int TW = sgm_pkg::PIX_W + 1;
   localparam logic signed [SW-1:0] K_SIDE = SW'(sgm_pkg::W_SIDE);
   localparam logic signed [SW-1:0] K_MID  = SW'(sgm_pkg::W_MID);

   logic                               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [TW-1:0]               tx_ff [3];
   logic signed [TW-1:0]               tx_in [3];
   logic [sgm_pkg::TY_W-1:0]           ty_ff [3];
   logic [sgm_pkg::TY_W-1:0]           ty_in [3];
   logic signed [sgm_pkg::GRAD_W-1:0]  gx_ff, gy_ff, gx_in, gy_in;
   logic signed [SW-1:0]               gx_wide, gy_wide;
   logic signed [2*sgm_pkg::GRAD_W-1:0] px, py;
   logic [sgm_pkg::SQP_W-1:0]          sqx_ff, sqy_ff;
   logic [sgm_pkg::SQ_W-1:0]           sum_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tx_in[k] = signed'({1'b0, pixels[k*3+2]}) - signed'({1'b0, pixels[k*3]});
         ty_in[k] = sgm_pkg::TY_W'(pixels[k*3]) * sgm_pkg::TY_W'(sgm_pkg::W_SIDE)
                  + sgm_pkg::TY_W'(pixels[k*3+1]) * sgm_pkg::TY_W'(sgm_pkg::W_MID)
                  + sgm_pkg::TY_W'(pixels[k*3+2]) * sgm_pkg::TY_W'(sgm_pkg::W_SIDE);
      end
      gx_wide = K_SIDE * SW'(tx_ff[0]) + K_MID * SW'(tx_ff[1]) + K_SIDE * SW'(tx_ff[2]);
      gy_wide = signed'({1'b0, ty_ff[2]}) - signed'({1'b0, ty_ff[0]});
      gx_in   = sgm_pkg::GRAD_W'(gx_wide);
      gy_in   = sgm_pkg::GRAD_W'(gy_wide);
      px      = gx_ff * gx_ff;
      py      = gy_ff * gy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
      end
      if (v1_ff) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (v2_ff) begin
         sqx_ff <= px[sgm_pkg::SQP_W-1:0];
         sqy_ff <= py[sgm_pkg::SQP_W-1:0];
      end
      if (v3_ff) begin
         sum_ff <= sgm_pkg::SQ_W'(sqx_ff) + sgm_pkg::SQ_W'(sqy_ff);
      end
   end

   assign sq_valid = v4_ff;
   assign sq       = sum_ff;
   assign grad_x   = gx_ff;
   assign grad_y   = gy_ff;

endmodule

@@ hdl/sgm_isqrt.sv @@
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle; done holds until ack.
// Uses sgm_pkg.
module sgm_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sgm_pkg::SQ_W-1:0]    radicand,
   input  logic                        ack,
   output logic                        done,
   output logic [sgm_pkg::MAG_W-1:0]   root
);

   localparam int RADW   = 2 * sgm_pkg::MAG_W;
   localparam int REMW   = sgm_pkg::MAG_W + 2;
   localparam int ACCW   = REMW + 2;
   localparam int STEP_W = $clog2(sgm_pkg::MAG_W);

   logic [RADW-1:0]            rad_ff, rad_in;
   logic [REMW-1:0]            rem_ff, rem_in;
   logic [sgm_pkg::MAG_W-1:0]  root_ff, root_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ACCW-1:0]            acc, sub;

   always_comb begin
      acc     = {rem_ff, rad_ff[RADW-1 -: 2]};
      sub     = ACCW'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rad_in  = RADW'(radicand);
         rem_in  = '0;
         root_in = '0;
         step_in = STEP_W'(sgm_pkg::MAG_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RADW-3:0], 2'b00};
         if (acc >= sub) begin
            rem_in  = REMW'(acc - sub);
            root_in = {root_ff[sgm_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in  = REMW'(acc);
            root_in = {root_ff[sgm_pkg::MAG_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ack) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hdl/scharr_gradient_magnitude.sv @@
`timescale 1ns / 1ps
// Scharr gradient and magnitude over a raster pixel stream; top level with CSRs.
// Uses sgm_pkg, sgm_line, sgm_grad and sgm_isqrt.
// A new pixel is taken only in idle: a border pixel takes a line store read, then write
// back; an interior pixel also waits for the 17-step square root unit.
// Reset: counters and window clear, width 640, height 480; line stores are not cleared.
module scharr_gradient_magnitude #(
   parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sgm_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [11:0] row, [21:12] col, [38:22] grad_x, [55:39] grad_y, [72:56] magnitude
   output logic [sgm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,   // frame_last
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sgm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sgm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   sgm_pkg::sgm_state_type              state_ff, state_in;
   logic [sgm_pkg::IMG_W_W-1:0]         width_ff;
   logic [sgm_pkg::IMG_H_W-1:0]         height_ff;
   logic                                csr_write;
   logic                                accept;
   logic                                load;
   logic                                grad_start;
   sgm_pkg::sgm_win_type                win;
   sgm_pkg::sgm_meta_type               meta;
   logic                                sq_valid;
   logic [sgm_pkg::SQ_W-1:0]            sq;
   logic signed [sgm_pkg::GRAD_W-1:0]   grad_x, grad_y;
   logic                                root_done;
   logic [sgm_pkg::MAG_W-1:0]           root;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sgm_pkg::ROW_W-1:0]           row_ff;
   logic [sgm_pkg::COL_W-1:0]           col_ff;
   logic [sgm_pkg::GRAD_W-1:0]          gx_ff, gy_ff;
   logic [sgm_pkg::MAG_W-1:0]           mag_ff;
   logic                                last_ff;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sgm_pkg::IMG_W_W'(sgm_pkg::WIDTH_RESET);
         height_ff <= sgm_pkg::IMG_H_W'(sgm_pkg::HEIGHT_RESET);
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            sgm_pkg::REG_IDX_WIDTH:  width_ff  <= csr_pwdata[sgm_pkg::IMG_W_W-1:0];
            sgm_pkg::REG_IDX_HEIGHT: height_ff <= csr_pwdata[sgm_pkg::IMG_H_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sgm_pkg::REG_IDX_WIDTH:  csr_prdata = sgm_pkg::CSR_DATA_W'(width_ff);
         sgm_pkg::REG_IDX_HEIGHT: csr_prdata = sgm_pkg::CSR_DATA_W'(height_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // datapath
   assign accept     = req_tvalid && req_tready;
   assign grad_start = win.valid && meta.emit;

   sgm_line #(.MAX_WIDTH(MAX_WIDTH)) u_line (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel        (req_tdata),
      .image_width  (width_ff),
      .image_height (height_ff),
      .win          (win),
      .meta         (meta)
   );

   sgm_grad u_grad (
      .clock    (clock),
      .reset    (reset),
      .start    (grad_start),
      .pixels   (win.pixels),
      .sq_valid (sq_valid),
      .sq       (sq),
      .grad_x   (grad_x),
      .grad_y   (grad_y)
   );

   sgm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_valid),
      .radicand (sq),
      .ack      (load),
      .done     (root_done),
      .root     (root)
   );

   // control
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         sgm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = sgm_pkg::ST_FETCH;
            end
         end
         sgm_pkg::ST_FETCH: begin
            state_in = meta.emit ? sgm_pkg::ST_CALC : sgm_pkg::ST_IDLE;
         end
         sgm_pkg::ST_CALC: begin
            if (root_done && (!rsp_valid_ff || rsp_tready)) begin
               load     = 1'b1;
               state_in = sgm_pkg::ST_IDLE;
            end
         end
         default: state_in = sgm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff  <= meta.row;
         col_ff  <= meta.col;
         gx_ff   <= grad_x;
         gy_ff   <= grad_y;
         mag_ff  <= root;
         last_ff <= meta.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{sgm_pkg::RSP_PAD_W{1'b0}}, mag_ff, gy_ff, gx_ff, col_ff, row_ff};
   assign rsp_tlast  = last_ff;

`ifndef ASSERT_OFF
   a_idle_no_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == sgm_pkg::ST_IDLE |-> !root_done)
      else $error("square root result pending while idle");

   a_emit_starts_grad: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgm_pkg::ST_FETCH && meta.emit) |=> grad_start)
      else $error("interior pixel did not start the gradient pipeline");

   a_sq_in_calc: assert property (@(posedge clock) disable iff (reset)
      sq_valid |-> state_ff == sgm_pkg::ST_CALC)
      else $error("gradient sum outside of calculation");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for scharr_gradient_magnitude: drives pixel frames of random
// sizes over the stream port, sets the frame size over the APB port and checks every result.
// Depends on sgm_pkg and the RTL top level only.

typedef struct packed {
   logic [sgm_pkg::ROW_W-1:0]  row;
   logic [sgm_pkg::COL_W-1:0]  col;
   logic [sgm_pkg::GRAD_W-1:0] grad_x;
   logic [sgm_pkg::GRAD_W-1:0] grad_y;
   logic [sgm_pkg::MAG_W-1:0]  magnitude;
   logic                       frame_last;
} gradient_result_type;

class gradient_scoreboard;
   logic [sgm_pkg::IMG_W_W-1:0] width_reg;
   logic [sgm_pkg::IMG_H_W-1:0] height_reg;
   logic [7:0]                  upper_line [sgm_pkg::MAX_WIDTH_DEFAULT];
   logic [7:0]                  middle_line [sgm_pkg::MAX_WIDTH_DEFAULT];
   logic [7:0]                  window [9];
   logic [sgm_pkg::COL_W-1:0]   col_cnt;
   logic [sgm_pkg::ROW_W-1:0]   row_cnt;
   gradient_result_type         expected_gradients [$];
   int                          errors;
   int                          pixels_taken;

   function new();
      width_reg    = sgm_pkg::WIDTH_RESET;
      height_reg   = sgm_pkg::HEIGHT_RESET;
      col_cnt      = '0;
      row_cnt      = '0;
      errors       = 0;
      pixels_taken = 0;
      foreach (window[k]) window[k] = '0;
      foreach (upper_line[k]) begin
         upper_line[k]  = '0;
         middle_line[k] = '0;
      end
   endfunction

   function void report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
   endfunction

   function void set_register(logic idx, logic [31:0] value);
      if (idx == sgm_pkg::REG_IDX_WIDTH) width_reg = value[sgm_pkg::IMG_W_W-1:0];
      else height_reg = value[sgm_pkg::IMG_H_W-1:0];
   endfunction

   function logic [31:0] register_value(logic idx);
      if (idx == sgm_pkg::REG_IDX_WIDTH) return 32'(width_reg);
      return 32'(height_reg);
   endfunction

   function bit frame_start();
      return col_cnt == 0 && row_cnt == 0;
   endfunction

   function logic [sgm_pkg::MAG_W-1:0] floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = sgm_pkg::MAG_W - 1; b >= 0; b--) begin
         cand = root | (longint'(1) << b);
         if (cand * cand <= v) root = cand;
      end
      return root[sgm_pkg::MAG_W-1:0];
   endfunction

   function void take_pixel(logic [7:0] px);
      int unsigned         w;
      int unsigned         h;
      bit                  row_end;
      bit                  frame_end;
      int                  a, b, d;
      int                  tx [3];
      int                  ty [3];
      int                  gx, gy;
      longint unsigned     sq;
      gradient_result_type res;
      w = (width_reg < sgm_pkg::MIN_DIM) ? sgm_pkg::MIN_DIM :
          (width_reg > sgm_pkg::MAX_WIDTH_DEFAULT) ? sgm_pkg::MAX_WIDTH_DEFAULT : width_reg;
      h = (height_reg < sgm_pkg::MIN_DIM) ? sgm_pkg::MIN_DIM : height_reg;
      row_end   = col_cnt >= w - 1;
      frame_end = row_end && (row_cnt >= h - 1);
      for (int k = 0; k < 3; k++) begin
         window[k*3]   = window[k*3+1];
         window[k*3+1] = window[k*3+2];
      end
      window[2]            = upper_line[col_cnt];
      window[5]            = middle_line[col_cnt];
      window[8]            = px;
      upper_line[col_cnt]  = middle_line[col_cnt];
      middle_line[col_cnt] = px;
      if (row_cnt >= 2 && col_cnt >= 2) begin
         for (int k = 0; k < 3; k++) begin
            a     = window[k*3];
            b     = window[k*3+1];
            d     = window[k*3+2];
            tx[k] = d - a;
            ty[k] = sgm_pkg::W_SIDE * a + sgm_pkg::W_MID * b + sgm_pkg::W_SIDE * d;
         end
         gx = sgm_pkg::W_SIDE * tx[0] + sgm_pkg::W_MID * tx[1] + sgm_pkg::W_SIDE * tx[2];
         gy = ty[2] - ty[0];
         sq = longint'(gx) * longint'(gx) + longint'(gy) * longint'(gy);
         res.row        = row_cnt - 1'b1;
         res.col        = col_cnt - 1'b1;
         res.grad_x     = gx[sgm_pkg::GRAD_W-1:0];
         res.grad_y     = gy[sgm_pkg::GRAD_W-1:0];
         res.magnitude  = floor_sqrt(sq);
         res.frame_last = frame_end;
         expected_gradients.push_back(res);
      end
      if (row_end) begin
         col_cnt = '0;
         row_cnt = frame_end ? '0 : row_cnt + 1'b1;
      end else begin
         col_cnt = col_cnt + 1'b1;
      end
      pixels_taken++;
   endfunction

   function void check_result(gradient_result_type got);
      gradient_result_type exp_res;
      if (expected_gradients.size() == 0) begin
         report($sformatf("result at row %0d col %0d with nothing pending", got.row, got.col));
         return;
      end
      exp_res = expected_gradients.pop_front();
      if (got.row !== exp_res.row)
         report($sformatf("row %0d, want %0d", got.row, exp_res.row));
      if (got.col !== exp_res.col)
         report($sformatf("col %0d, want %0d", got.col, exp_res.col));
      if (got.grad_x !== exp_res.grad_x)
         report($sformatf("grad_x %0d, want %0d at (%0d,%0d)", $signed(got.grad_x),
                          $signed(exp_res.grad_x), exp_res.row, exp_res.col));
      if (got.grad_y !== exp_res.grad_y)
         report($sformatf("grad_y %0d, want %0d at (%0d,%0d)", $signed(got.grad_y),
                          $signed(exp_res.grad_y), exp_res.row, exp_res.col));
      if (got.magnitude !== exp_res.magnitude)
         report($sformatf("magnitude %0d, want %0d at (%0d,%0d)", got.magnitude,
                          exp_res.magnitude, exp_res.row, exp_res.col));
      if (got.frame_last !== exp_res.frame_last)
         report($sformatf("frame_last %0b, want %0b at (%0d,%0d)", got.frame_last,
                          exp_res.frame_last, exp_res.row, exp_res.col));
   endfunction
endclass

module testbench;

   localparam int COL_LSB = sgm_pkg::ROW_W;
   localparam int GX_LSB  = sgm_pkg::ROW_W + sgm_pkg::COL_W;
   localparam int GY_LSB  = GX_LSB + sgm_pkg::GRAD_W;
   localparam int MAG_LSB = GY_LSB + sgm_pkg::GRAD_W;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [sgm_pkg::PIX_W-1:0]       req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [sgm_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [sgm_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [sgm_pkg::CSR_DATA_W-1:0]  csr_pwdata;
   logic [sgm_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   int                              req_gap_pct;
   int                              rsp_stall_pct;
   gradient_scoreboard              sb;
   gradient_result_type             got;

   scharr_gradient_magnitude u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("testbench: errors");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready = (rsp_stall_pct == 0) || ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row        = rsp_tdata[0 +: sgm_pkg::ROW_W];
         got.col        = rsp_tdata[COL_LSB +: sgm_pkg::COL_W];
         got.grad_x     = rsp_tdata[GX_LSB +: sgm_pkg::GRAD_W];
         got.grad_y     = rsp_tdata[GY_LSB +: sgm_pkg::GRAD_W];
         got.magnitude  = rsp_tdata[MAG_LSB +: sgm_pkg::MAG_W];
         got.frame_last = rsp_tlast;
         sb.check_result(got);
      end
   end

   task automatic csr_access(input logic wr, input logic idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic check_register(input logic idx);
      logic [31:0] rd;
      csr_access(1'b0, idx, '0, rd);
      if (rd !== sb.register_value(idx))
         sb.report($sformatf("register %0d reads %0d, want %0d", idx, rd,
                             sb.register_value(idx)));
   endtask

   task automatic write_register(input logic idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_access(1'b1, idx, value, rd);
      sb.set_register(idx, value);
      check_register(idx);
   endtask

   task automatic send_pixel(input logic [7:0] px);
      while (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = px;
      do @(posedge clock); while (!req_tready);
      sb.take_pixel(px);
      @(negedge clock);
   endtask

   // hold off until every pending result has been transferred and the pipe is empty
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.expected_gradients.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_pixel(int mode);
      case (mode)
         1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         2: return 8'($urandom_range(100, 140));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_frame(input int unsigned wval, input int unsigned hval, input bit resize);
      int unsigned eff_w;
      int unsigned eff_h;
      int          mode;
      wait_drained();
      write_register(sgm_pkg::REG_IDX_WIDTH, wval);
      write_register(sgm_pkg::REG_IDX_HEIGHT, hval);
      eff_w = (wval < sgm_pkg::MIN_DIM) ? sgm_pkg::MIN_DIM :
              (wval > sgm_pkg::MAX_WIDTH_DEFAULT) ? sgm_pkg::MAX_WIDTH_DEFAULT : wval;
      eff_h = (hval < sgm_pkg::MIN_DIM) ? sgm_pkg::MIN_DIM : hval;
      mode  = $urandom_range(0, 3);
      if (resize) begin
         repeat ($urandom_range(1, eff_w * eff_h - 1)) send_pixel(pick_pixel(mode));
         wait_drained();
         // shrink the width only, so no line store entry is read before it is filled
         if (eff_w > sgm_pkg::MIN_DIM && $urandom_range(0, 1))
            write_register(sgm_pkg::REG_IDX_WIDTH, $urandom_range(0, eff_w - 1));
         else
            write_register(sgm_pkg::REG_IDX_HEIGHT, $urandom_range(0, 8));
      end
      do send_pixel(pick_pixel(mode)); while (!sb.frame_start());
   endtask

   // full-range register values, then cut the row and the frame short mid-frame
   task automatic run_extremes();
      wait_drained();
      write_register(sgm_pkg::REG_IDX_WIDTH, (1 << sgm_pkg::IMG_W_W) - 1);
      write_register(sgm_pkg::REG_IDX_HEIGHT, (1 << sgm_pkg::IMG_H_W) - 1);
      repeat (12) send_pixel(pick_pixel(0));
      wait_drained();
      write_register(sgm_pkg::REG_IDX_WIDTH, 0);
      repeat (9) send_pixel(pick_pixel(0));
      wait_drained();
      write_register(sgm_pkg::REG_IDX_HEIGHT, 0);
      do send_pixel(pick_pixel(0)); while (!sb.frame_start());
   endtask

   logic [7:0] directed_pixels [27] = '{
      8'd0,   8'd128, 8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd128, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd7,   8'd7,   8'd7,   8'd0,   8'd0,   8'd0,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0
   };

   initial begin
      int target;
      int unsigned wval;
      int unsigned hval;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_gap_pct   = 27;
      rsp_stall_pct = 60;
      sb            = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      check_register(sgm_pkg::REG_IDX_WIDTH);
      check_register(sgm_pkg::REG_IDX_HEIGHT);

      // three 3x3 frames: full positive x edge, full negative y edge, diagonal corner
      write_register(sgm_pkg::REG_IDX_WIDTH, 3);
      write_register(sgm_pkg::REG_IDX_HEIGHT, 3);
      foreach (directed_pixels[k]) send_pixel(directed_pixels[k]);

      for (int phase = 0; phase < 3; phase++) begin
         req_gap_pct   = (phase == 0) ? 27 : (phase == 1) ? 60 : 0;
         rsp_stall_pct = (phase == 0) ? 60 : (phase == 1) ? 27 : 0;
         target        = sb.pixels_taken + 115;
         while (sb.pixels_taken < target) begin
            wval = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            hval = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            run_frame(wval, hval, $urandom_range(0, 4) == 0);
         end
      end

      run_extremes();

      wait_drained();
      if (sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/sgm_pkg.sv
hdl/sgm_ram.sv
hdl/sgm_line.sv
hdl/sgm_grad.sv
hdl/sgm_isqrt.sv
hdl/scharr_gradient_magnitude.sv
dv/testbench.sv
